[rtl/core/gimbal_mode_and_scan_target_unit_macros.svh]
// Assertion macros for the gimbal mode and scan target unit.
// Included by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef GIMBAL_MODE_AND_SCAN_TARGET_UNIT_MACROS_SVH
`define GIMBAL_MODE_AND_SCAN_TARGET_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GMST_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gmst: same-cycle check failed");
// next-cycle implication
`define GMST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmst: next-cycle check failed");
`else
`define GMST_ASSERT_IMPLY(label, ante, cons)
`define GMST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/gmst_pkg.sv]
// Shared types and constants for the gimbal mode and scan target unit.
// No dependencies; used by the channel interfaces and the top level.
package gmst_pkg;

	localparam int ANGLE_W      = 32;
	localparam int COUNT_W      = 16;
	localparam int SCAN_W       = 4;
	localparam int PSTEP_W      = 31;
	localparam int CMD_W        = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	// pitch sums need two guard bits above the angle width
	localparam int PITCH_WIDE_W = ANGLE_W + 2;

	// gimbal modes
	typedef enum logic [1:0] {
		MODE_PREPARE = 2'd0,
		MODE_CRUISE  = 2'd1,
		MODE_SHOOT   = 2'd2,
		MODE_REMOTE  = 2'd3
	} mode_t;

	// host command kinds; the unused code acts as none
	localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MOVE_BY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MOVE_TO = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PREPARE_TICKS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_START_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_SCAN_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_SCAN_STEP   = 3'd5;

	// register reset values
	localparam logic [COUNT_W-1:0]        PREPARE_TICKS_RST     = 16'd4000;
	localparam logic signed [ANGLE_W-1:0] PITCH_LOW_LIMIT_RST   = -32'sd1310720;
	localparam logic signed [ANGLE_W-1:0] PITCH_HIGH_LIMIT_RST  = 32'sd1966080;
	localparam logic signed [ANGLE_W-1:0] PITCH_START_ANGLE_RST = 32'sd0;
	localparam logic signed [ANGLE_W-1:0] YAW_SCAN_STEP_RST     = 32'sd65536;
	localparam logic [PSTEP_W-1:0]        PITCH_SCAN_STEP_RST   = 31'd32768;

	// scan timing: a step when the wrapped tick count passes this value
	localparam logic [SCAN_W-1:0] SCAN_PERIOD = 4'd10;
	// bounce margin, five degrees in Q16.16
	localparam logic signed [PITCH_WIDE_W-1:0] SCAN_MARGIN = 34'sd327680;

endpackage

[rtl/core/gmst_tick_if.sv]
// Tick request channel of the gimbal mode and scan target unit.
// Depends on gmst_pkg for field widths.
interface gmst_tick_if
	import gmst_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] yaw_measured;
	logic signed [ANGLE_W-1:0] pitch_encoder;
	logic                      host_online;
	logic                      remote_mode;
	logic [CMD_W-1:0]          host_cmd_kind;
	logic signed [ANGLE_W-1:0] host_yaw_value;
	logic signed [ANGLE_W-1:0] host_pitch_value;

	modport source (
		output valid, yaw_measured, pitch_encoder, host_online, remote_mode,
		       host_cmd_kind, host_yaw_value, host_pitch_value,
		input  ready
	);
	modport sink (
		input  valid, yaw_measured, pitch_encoder, host_online, remote_mode,
		       host_cmd_kind, host_yaw_value, host_pitch_value,
		output ready
	);
endinterface

[rtl/core/gmst_goal_if.sv]
// Result request channel of the gimbal mode and scan target unit.
// Depends on gmst_pkg for the mode type and field widths.
interface gmst_goal_if
	import gmst_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	mode_t                     mode;
	logic signed [ANGLE_W-1:0] yaw_goal;
	logic signed [ANGLE_W-1:0] pitch_goal;
	logic                      pitch_at_limit;
	logic                      friction_start;
	logic                      chassis_clear;

	modport source (
		output valid, mode, yaw_goal, pitch_goal, pitch_at_limit, friction_start,
		       chassis_clear,
		input  ready
	);
	modport sink (
		input  valid, mode, yaw_goal, pitch_goal, pitch_at_limit, friction_start,
		       chassis_clear,
		output ready
	);
endinterface

[rtl/core/gimbal_mode_and_scan_target_unit.sv]
// Gimbal mode and scan target unit: top level.
// Depends on gmst_pkg, gmst_tick_if, gmst_goal_if and the assertion macro header.
//
// Usage:
//   One request on the tick channel per 1 ms control tick carries the measured
//   yaw, the pitch encoder, the host and remote flags and the host command.
//   For each tick the goal channel returns exactly one request: the new mode,
//   the yaw and clamped pitch targets, the limit flag, the one-shot
//   friction-start pulse and the chassis-clear pulse.
//   Registers are written through wr_en / wr_index / wr_data while the unit is
//   idle; indexes above the list are ignored.
// Timing:
//   A tick sits in an input register while the mode machine and target logic
//   run; the result is loaded into the output register once that register is
//   free, and the state update happens at that same edge, so one tick per cycle
//   is sustained while the receiver keeps ready high.
// Reset:
//   arst_n puts the unit in prepare with zero counters and targets, both
//   one-shots armed, and the registers at their defaults.
// Stall:
//   While the receiver holds ready low the result is kept; one further tick
//   is held in the input register, after which tick.ready drops.
`include "gimbal_mode_and_scan_target_unit_macros.svh"

module gimbal_mode_and_scan_target_unit
	import gmst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	gmst_tick_if.sink             tick,
	gmst_goal_if.source           goal
);

	// configuration registers
	logic [COUNT_W-1:0]        prepare_ticks_q;
	logic signed [ANGLE_W-1:0] pitch_low_q;
	logic signed [ANGLE_W-1:0] pitch_high_q;
	logic signed [ANGLE_W-1:0] pitch_start_q;
	logic signed [ANGLE_W-1:0] yaw_step_q;
	logic [PSTEP_W-1:0]        pitch_step_q;

	// block state
	mode_t                     mode_q;
	logic [COUNT_W-1:0]        prepare_count_q;
	logic [SCAN_W-1:0]         scan_count_q;
	logic                      going_down_q;
	logic                      prepare_pending_q;
	logic                      cruise_pending_q;
	logic signed [ANGLE_W-1:0] yaw_goal_q;
	logic signed [ANGLE_W-1:0] pitch_goal_q;

	// input stage
	logic                      valid_s1;
	logic signed [ANGLE_W-1:0] yaw_meas_s1;
	logic signed [ANGLE_W-1:0] pitch_enc_s1;
	logic                      host_s1;
	logic                      remote_s1;
	logic [CMD_W-1:0]          kind_s1;
	logic signed [ANGLE_W-1:0] host_yaw_s1;
	logic signed [ANGLE_W-1:0] host_pitch_s1;

	// result stage
	logic                      valid_s2;
	mode_t                     mode_s2;
	logic signed [ANGLE_W-1:0] yaw_goal_s2;
	logic signed [ANGLE_W-1:0] pitch_goal_s2;
	logic                      at_limit_s2;
	logic                      fric_s2;
	logic                      clear_s2;

	// handshake
	logic res_free;
	logic s1_fire;
	logic tick_fire;

	// next-state values
	mode_t                     mode_nx;
	logic                      clear_nx;
	logic [COUNT_W-1:0]        count_inc;
	logic [COUNT_W-1:0]        prepare_count_nx;
	logic [SCAN_W-1:0]         scan_inc;
	logic [SCAN_W-1:0]         scan_count_nx;
	logic                      going_down_nx;
	logic                      prepare_pending_nx;
	logic                      cruise_pending_nx;
	logic                      fric_nx;
	logic signed [ANGLE_W-1:0] yaw_nx;
	logic signed [ANGLE_W-1:0] pitch_nx;
	logic                      at_limit_nx;

	// wide pitch arithmetic
	logic signed [PITCH_WIDE_W-1:0] pitch_base_w;
	logic signed [PITCH_WIDE_W-1:0] pitch_step_w;
	logic signed [PITCH_WIDE_W-1:0] low_w;
	logic signed [PITCH_WIDE_W-1:0] high_w;
	logic signed [PITCH_WIDE_W-1:0] pitch_w;

	assign res_free   = !valid_s2 || goal.ready;
	assign s1_fire    = valid_s1 && res_free;
	assign tick.ready = !valid_s1 || res_free;
	assign tick_fire  = tick.valid && tick.ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prepare_ticks_q <= PREPARE_TICKS_RST;
			pitch_low_q     <= PITCH_LOW_LIMIT_RST;
			pitch_high_q    <= PITCH_HIGH_LIMIT_RST;
			pitch_start_q   <= PITCH_START_ANGLE_RST;
			yaw_step_q      <= YAW_SCAN_STEP_RST;
			pitch_step_q    <= PITCH_SCAN_STEP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PREPARE_TICKS:     prepare_ticks_q <= wr_data[COUNT_W-1:0];
				REG_PITCH_LOW_LIMIT:   pitch_low_q     <= wr_data[ANGLE_W-1:0];
				REG_PITCH_HIGH_LIMIT:  pitch_high_q    <= wr_data[ANGLE_W-1:0];
				REG_PITCH_START_ANGLE: pitch_start_q   <= wr_data[ANGLE_W-1:0];
				REG_YAW_SCAN_STEP:     yaw_step_q      <= wr_data[ANGLE_W-1:0];
				REG_PITCH_SCAN_STEP:   pitch_step_q    <= wr_data[PSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (tick_fire) begin
			yaw_meas_s1   <= tick.yaw_measured;
			pitch_enc_s1  <= tick.pitch_encoder;
			host_s1       <= tick.host_online;
			remote_s1     <= tick.remote_mode;
			kind_s1       <= tick.host_cmd_kind;
			host_yaw_s1   <= tick.host_yaw_value;
			host_pitch_s1 <= tick.host_pitch_value;
		end
	end

	// mode machine: next state
	always_comb begin
		count_inc = (prepare_count_q != {COUNT_W{1'b1}}) ?
			prepare_count_q + COUNT_W'(1) : prepare_count_q;
		mode_nx  = mode_q;
		unique case (mode_q)
			MODE_PREPARE: begin
				if (count_inc > prepare_ticks_q) mode_nx = MODE_CRUISE;
			end
			MODE_CRUISE: begin
				if (remote_s1)    mode_nx = MODE_REMOTE;
				else if (host_s1) mode_nx = MODE_SHOOT;
			end
			MODE_SHOOT: begin
				if (!host_s1) mode_nx = MODE_CRUISE;
			end
			MODE_REMOTE: begin
				if (host_s1)         mode_nx = MODE_SHOOT;
				else if (!remote_s1) mode_nx = MODE_CRUISE;
			end
		endcase
		prepare_count_nx = (mode_q == MODE_PREPARE) ? count_inc : prepare_count_q;
	end

	// mode machine: outputs, targets for the new mode
	always_comb begin
		clear_nx           = (mode_q == MODE_REMOTE) && (host_s1 || !remote_s1);
		pitch_base_w       = {{(PITCH_WIDE_W-ANGLE_W){pitch_goal_q[ANGLE_W-1]}}, pitch_goal_q};
		pitch_step_w       = {{(PITCH_WIDE_W-PSTEP_W){1'b0}}, pitch_step_q};
		low_w              = {{(PITCH_WIDE_W-ANGLE_W){pitch_low_q[ANGLE_W-1]}}, pitch_low_q};
		high_w             = {{(PITCH_WIDE_W-ANGLE_W){pitch_high_q[ANGLE_W-1]}}, pitch_high_q};
		scan_inc           = scan_count_q + SCAN_W'(1);
		pitch_w            = pitch_base_w;
		yaw_nx             = yaw_goal_q;
		scan_count_nx      = scan_count_q;
		going_down_nx      = going_down_q;
		prepare_pending_nx = prepare_pending_q;
		cruise_pending_nx  = cruise_pending_q;
		fric_nx            = 1'b0;
		unique case (mode_nx)
			MODE_PREPARE: begin
				yaw_nx = yaw_meas_s1;
				if (prepare_pending_q && (pitch_enc_s1 != '0)) begin
					pitch_w = {{(PITCH_WIDE_W-ANGLE_W){pitch_start_q[ANGLE_W-1]}},
						pitch_start_q};
					prepare_pending_nx = 1'b0;
				end
			end
			MODE_CRUISE: begin
				if (cruise_pending_q) begin
					fric_nx           = 1'b1;
					cruise_pending_nx = 1'b0;
				end
				scan_count_nx = scan_inc;
				if (scan_inc > SCAN_PERIOD) begin
					yaw_nx  = yaw_goal_q + yaw_step_q;
					pitch_w = going_down_q ? pitch_base_w - pitch_step_w :
						pitch_base_w + pitch_step_w;
					// reversal at the margins; the low test wins
					if (pitch_w > high_w - SCAN_MARGIN) going_down_nx = 1'b1;
					if (pitch_w < low_w + SCAN_MARGIN)  going_down_nx = 1'b0;
					scan_count_nx = '0;
				end
			end
			MODE_SHOOT: begin
				if (kind_s1 == CMD_MOVE_BY) begin
					yaw_nx  = yaw_goal_q + host_yaw_s1;
					pitch_w = pitch_base_w + {{(PITCH_WIDE_W-ANGLE_W){host_pitch_s1[ANGLE_W-1]}},
						host_pitch_s1};
				end else if (kind_s1 == CMD_MOVE_TO) begin
					yaw_nx  = host_yaw_s1;
					pitch_w = {{(PITCH_WIDE_W-ANGLE_W){host_pitch_s1[ANGLE_W-1]}},
						host_pitch_s1};
				end
			end
			MODE_REMOTE: ;
		endcase

		// pitch clamp, low limit checked first
		priority if (pitch_w <= low_w) begin
			pitch_nx    = pitch_low_q;
			at_limit_nx = 1'b1;
		end else if (pitch_w >= high_w) begin
			pitch_nx    = pitch_high_q;
			at_limit_nx = 1'b1;
		end else begin
			pitch_nx    = pitch_w[ANGLE_W-1:0];
			at_limit_nx = 1'b0;
		end
	end

	// state update, once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= MODE_PREPARE;
			prepare_count_q   <= '0;
			scan_count_q      <= '0;
			going_down_q      <= 1'b0;
			prepare_pending_q <= 1'b1;
			cruise_pending_q  <= 1'b1;
			yaw_goal_q        <= '0;
			pitch_goal_q      <= '0;
		end else if (s1_fire) begin
			mode_q            <= mode_nx;
			prepare_count_q   <= prepare_count_nx;
			scan_count_q      <= scan_count_nx;
			going_down_q      <= going_down_nx;
			prepare_pending_q <= prepare_pending_nx;
			cruise_pending_q  <= cruise_pending_nx;
			yaw_goal_q        <= yaw_nx;
			pitch_goal_q      <= pitch_nx;
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			valid_s2 <= 1'b1;
		end else if (goal.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			mode_s2       <= mode_nx;
			yaw_goal_s2   <= yaw_nx;
			pitch_goal_s2 <= pitch_nx;
			at_limit_s2   <= at_limit_nx;
			fric_s2       <= fric_nx;
			clear_s2      <= clear_nx;
		end
	end

	assign goal.valid          = valid_s2;
	assign goal.mode           = mode_s2;
	assign goal.yaw_goal       = yaw_goal_s2;
	assign goal.pitch_goal     = pitch_goal_s2;
	assign goal.pitch_at_limit = at_limit_s2;
	assign goal.friction_start = fric_s2;
	assign goal.chassis_clear  = clear_s2;

	// checks
	`GMST_ASSERT_IMPLY(a_clear_leaves_remote, valid_s2 && clear_s2, mode_s2 != MODE_REMOTE)
	`GMST_ASSERT_IMPLY(a_fric_in_cruise, valid_s2 && fric_s2, (mode_s2 == MODE_CRUISE) && !cruise_pending_q)
	`GMST_ASSERT_IMPLY(a_limit_value, valid_s2 && at_limit_s2, (pitch_goal_s2 == pitch_low_q) || (pitch_goal_s2 == pitch_high_q))
	`GMST_ASSERT_NEXT(a_count_holds, !s1_fire, $stable(prepare_count_q) && $stable(mode_q))

endmodule

[tb/tb.sv]
// Self-checking bench for the gimbal mode and scan target unit: directed table, then random ticks.
// Depends on gmst_pkg, gmst_tick_if, gmst_goal_if and gimbal_mode_and_scan_target_unit.
module tb;
	import gmst_pkg::*;

	localparam int DEG = 65536;

	// one tick request and one goal request, as the bench sees them
	typedef struct packed {
		logic signed [ANGLE_W-1:0] yaw_meas;
		logic signed [ANGLE_W-1:0] pitch_enc;
		logic                      host;
		logic                      remote;
		logic [CMD_W-1:0]          cmd;
		logic signed [ANGLE_W-1:0] host_yaw;
		logic signed [ANGLE_W-1:0] host_pitch;
	} tick_rec_t;

	typedef struct packed {
		mode_t              mode;
		logic [ANGLE_W-1:0] yaw;
		logic [ANGLE_W-1:0] pitch;
		logic               lim;
		logic               fric;
		logic               clr;
	} goal_rec_t;

	typedef enum {ROW_TICK, ROW_REG, ROW_SOAK} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		tick_rec_t             t;
		bit                    has_exp;
		goal_rec_t             e;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	gmst_tick_if tick_ch ();
	gmst_goal_if goal_ch ();

	gimbal_mode_and_scan_target_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.tick     (tick_ch),
		.goal     (goal_ch)
	);

	// register copies
	logic [COUNT_W-1:0]        c_prep_ticks;
	logic signed [ANGLE_W-1:0] c_low;
	logic signed [ANGLE_W-1:0] c_high;
	logic signed [ANGLE_W-1:0] c_start;
	logic signed [ANGLE_W-1:0] c_yaw_step;
	logic [PSTEP_W-1:0]        c_pitch_step;

	// predicted gimbal state
	mode_t                     gm_mode;
	logic [COUNT_W-1:0]        gm_prep_cnt;
	logic [SCAN_W-1:0]         gm_scan_cnt;
	logic                      gm_pitch_down;
	logic                      gm_start_armed;
	logic                      gm_fric_armed;
	logic [ANGLE_W-1:0]        gm_yaw;
	logic signed [ANGLE_W-1:0] gm_pitch;

	goal_rec_t pending_goals[$];
	goal_rec_t want_g;
	stim_row_t rows[$];
	int        bad;
	int        src_idle_pct;
	int        snk_stall_pct;
	logic      host_hold;
	logic      remote_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic void reset_gimbal();
		c_prep_ticks   = PREPARE_TICKS_RST;
		c_low          = PITCH_LOW_LIMIT_RST;
		c_high         = PITCH_HIGH_LIMIT_RST;
		c_start        = PITCH_START_ANGLE_RST;
		c_yaw_step     = YAW_SCAN_STEP_RST;
		c_pitch_step   = PITCH_SCAN_STEP_RST;
		gm_mode        = MODE_PREPARE;
		gm_prep_cnt    = '0;
		gm_scan_cnt    = '0;
		gm_pitch_down  = 1'b0;
		gm_start_armed = 1'b1;
		gm_fric_armed  = 1'b1;
		gm_yaw         = '0;
		gm_pitch       = '0;
	endfunction

	// one control tick: mode machine first, then the targets for the new mode
	function automatic goal_rec_t step_gimbal(tick_rec_t t);
		goal_rec_t g;
		longint    p;
		logic      clr;
		logic      fric;
		logic      lim;
		clr  = 1'b0;
		fric = 1'b0;
		lim  = 1'b0;
		p    = gm_pitch;
		case (gm_mode)
			MODE_PREPARE: begin
				if (gm_prep_cnt != '1)
					gm_prep_cnt = gm_prep_cnt + 1'b1;
				if (gm_prep_cnt > c_prep_ticks)
					gm_mode = MODE_CRUISE;
			end
			MODE_CRUISE: begin
				if (t.host)
					gm_mode = MODE_SHOOT;
				if (t.remote)
					gm_mode = MODE_REMOTE;
			end
			MODE_SHOOT: begin
				if (!t.host)
					gm_mode = MODE_CRUISE;
			end
			default: begin
				if (!t.remote) begin
					gm_mode = MODE_CRUISE;
					clr = 1'b1;
				end
				if (t.host) begin
					gm_mode = MODE_SHOOT;
					clr = 1'b1;
				end
			end
		endcase

		case (gm_mode)
			MODE_PREPARE: begin
				gm_yaw = t.yaw_meas;
				if (gm_start_armed && t.pitch_enc != 0) begin
					p = c_start;
					gm_start_armed = 1'b0;
				end
			end
			MODE_CRUISE: begin
				if (gm_fric_armed) begin
					fric = 1'b1;
					gm_fric_armed = 1'b0;
				end
				gm_scan_cnt = gm_scan_cnt + 1'b1;
				if (gm_scan_cnt > SCAN_PERIOD) begin
					gm_yaw = gm_yaw + c_yaw_step;
					if (gm_pitch_down)
						p = p - longint'(c_pitch_step);
					else
						p = p + longint'(c_pitch_step);
					// bounce tests in wide arithmetic; the low side has the last word
					if (p > longint'(c_high) - longint'(SCAN_MARGIN))
						gm_pitch_down = 1'b1;
					if (p < longint'(c_low) + longint'(SCAN_MARGIN))
						gm_pitch_down = 1'b0;
					gm_scan_cnt = '0;
				end
			end
			MODE_SHOOT: begin
				if (t.cmd == CMD_MOVE_BY) begin
					gm_yaw = gm_yaw + t.host_yaw;
					p = p + longint'(t.host_pitch);
				end else if (t.cmd == CMD_MOVE_TO) begin
					gm_yaw = t.host_yaw;
					p = t.host_pitch;
				end
			end
			default: ;
		endcase

		// low limit checked first, which also settles crossed limits
		if (p <= longint'(c_low)) begin
			p = c_low;
			lim = 1'b1;
		end else if (p >= longint'(c_high)) begin
			p = c_high;
			lim = 1'b1;
		end
		gm_pitch = p[ANGLE_W-1:0];

		g.mode  = gm_mode;
		g.yaw   = gm_yaw;
		g.pitch = gm_pitch;
		g.lim   = lim;
		g.fric  = fric;
		g.clr   = clr;
		return g;
	endfunction

	function automatic void set_idling(int m);
		case (m)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 55; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 55; end
			default: begin src_idle_pct = 13; snk_stall_pct = 13; end
		endcase
	endfunction

	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(1048576)) - 524288;
		endcase
	endfunction

	// host and remote flags mostly hold for stretches so cruise lasts long enough to scan
	function automatic tick_rec_t random_tick();
		tick_rec_t t;
		if ($urandom_range(15) == 0) begin
			host_hold   = ($urandom_range(3) == 0);
			remote_hold = ($urandom_range(4) == 0);
		end
		t.yaw_meas  = $urandom;
		t.pitch_enc = ($urandom_range(3) == 0) ? '0 : $urandom;
		if ($urandom_range(11) == 0) begin
			t.host   = 1'($urandom_range(1));
			t.remote = 1'($urandom_range(1));
		end else begin
			t.host   = host_hold;
			t.remote = remote_hold;
		end
		t.cmd        = CMD_W'($urandom_range(3));
		t.host_yaw   = pick_angle();
		t.host_pitch = pick_angle();
		return t;
	endfunction

	function automatic void push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r.kind    = ROW_REG;
		r.idx     = idx;
		r.val     = val;
		r.t       = '0;
		r.has_exp = 1'b0;
		r.e       = '0;
		rows.push_back(r);
	endfunction

	function automatic void push_tick(input logic signed [ANGLE_W-1:0] ym, pe,
			input logic h, rm, input logic [CMD_W-1:0] cmd,
			input logic signed [ANGLE_W-1:0] hy, hp);
		stim_row_t r;
		r.kind         = ROW_TICK;
		r.idx          = '0;
		r.val          = '0;
		r.t.yaw_meas   = ym;
		r.t.pitch_enc  = pe;
		r.t.host       = h;
		r.t.remote     = rm;
		r.t.cmd        = cmd;
		r.t.host_yaw   = hy;
		r.t.host_pitch = hp;
		r.has_exp      = 1'b0;
		r.e            = '0;
		rows.push_back(r);
	endfunction

	// typed rows never carry a pulse
	function automatic void add_goal(mode_t m, logic [ANGLE_W-1:0] yaw,
			logic [ANGLE_W-1:0] pitch, logic lim);
		rows[rows.size()-1].has_exp = 1'b1;
		rows[rows.size()-1].e       = '{m, yaw, pitch, lim, 1'b0, 1'b0};
	endfunction

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_PREPARE_TICKS:     c_prep_ticks = val[COUNT_W-1:0];
			REG_PITCH_LOW_LIMIT:   c_low        = val;
			REG_PITCH_HIGH_LIMIT:  c_high       = val;
			REG_PITCH_START_ANGLE: c_start      = val;
			REG_YAW_SCAN_STEP:     c_yaw_step   = val;
			REG_PITCH_SCAN_STEP:   c_pitch_step = val[PSTEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_set(logic [CFG_DATA_W-1:0] pt, lo, hi, st, ys, ps);
		apply_reg(REG_PREPARE_TICKS, pt);
		apply_reg(REG_PITCH_LOW_LIMIT, lo);
		apply_reg(REG_PITCH_HIGH_LIMIT, hi);
		apply_reg(REG_PITCH_START_ANGLE, st);
		apply_reg(REG_YAW_SCAN_STEP, ys);
		apply_reg(REG_PITCH_SCAN_STEP, ps);
		wr_en <= 1'b0;
	endtask

	// registers change only once every goal has come back
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (pending_goals.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// offer one tick request, held until taken; called and left at a falling edge
	task automatic send_tick(tick_rec_t t, bit has_exp, goal_rec_t e);
		goal_rec_t g;
		while ($urandom_range(99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid            <= 1'b1;
		tick_ch.yaw_measured     <= t.yaw_meas;
		tick_ch.pitch_encoder    <= t.pitch_enc;
		tick_ch.host_online      <= t.host;
		tick_ch.remote_mode      <= t.remote;
		tick_ch.host_cmd_kind    <= t.cmd;
		tick_ch.host_yaw_value   <= t.host_yaw;
		tick_ch.host_pitch_value <= t.host_pitch;
		@(posedge clk);
		while (tick_ch.ready !== 1'b1)
			@(posedge clk);
		g = step_gimbal(t);
		pending_goals.push_back(has_exp ? e : g);
		@(negedge clk);
	endtask

	// receiver stalls
	initial begin
		goal_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			goal_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// goal checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && goal_ch.valid === 1'b1 && goal_ch.ready === 1'b1) begin
			if (pending_goals.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("tb: goal request with none expected");
			end else begin
				want_g = pending_goals.pop_front();
				if (goal_ch.mode !== want_g.mode || goal_ch.yaw_goal !== want_g.yaw ||
						goal_ch.pitch_goal !== want_g.pitch ||
						goal_ch.pitch_at_limit !== want_g.lim ||
						goal_ch.friction_start !== want_g.fric ||
						goal_ch.chassis_clear !== want_g.clr) begin
					bad++;
					if (bad <= 10)
						$display("tb: mismatch exp %0d %h %h %b%b%b got %0d %h %h %b%b%b",
							want_g.mode, want_g.yaw, want_g.pitch,
							want_g.lim, want_g.fric, want_g.clr,
							goal_ch.mode, goal_ch.yaw_goal, goal_ch.pitch_goal,
							goal_ch.pitch_at_limit, goal_ch.friction_start,
							goal_ch.chassis_clear);
				end
			end
		end
	end

	initial begin
		bad         = 0;
		host_hold   = 1'b0;
		remote_hold = 1'b0;
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = '0;
		wr_data     = '0;
		tick_ch.valid            = 1'b0;
		tick_ch.yaw_measured     = '0;
		tick_ch.pitch_encoder    = '0;
		tick_ch.host_online      = 1'b0;
		tick_ch.remote_mode      = 1'b0;
		tick_ch.host_cmd_kind    = CMD_NONE;
		tick_ch.host_yaw_value   = '0;
		tick_ch.host_pitch_value = '0;
		set_idling(3);
		reset_gimbal();

		// prepare held by a full tick count; start angle beyond the high limit
		push_reg(REG_PREPARE_TICKS, 32'hFFFF);
		push_reg(REG_PITCH_START_ANGLE, 32'h7FFF_FFFF);
		push_tick(32'h7FFF_FFFF, 0, 1, 1, CMD_MOVE_TO, 5 * DEG, 5 * DEG);
		add_goal(MODE_PREPARE, 32'h7FFF_FFFF, 0, 1'b0);
		push_tick(32'h8000_0000, 0, 0, 0, CMD_MOVE_BY, DEG, DEG);
		add_goal(MODE_PREPARE, 32'h8000_0000, 0, 1'b0);
		push_tick(3 * DEG, 1, 0, 1, CMD_NONE, 0, 0);
		add_goal(MODE_PREPARE, 3 * DEG, PITCH_HIGH_LIMIT_RST, 1'b1);
		// encoder valid again, the start angle is not taken twice
		push_tick(-3 * DEG, 32'h8000_0000, 1, 0, 2'd3, 0, 0);
		add_goal(MODE_PREPARE, -3 * DEG, PITCH_HIGH_LIMIT_RST, 1'b1);
		// a stretch of random ticks while prepare is held
		rows.push_back('{ROW_SOAK, '0, 32'd40, '0, 1'b0, '0});
		push_reg(REG_PREPARE_TICKS, 32'd0);
		// first cruise tick fires friction start
		push_tick(10 * DEG, 0, 0, 0, CMD_NONE, 0, 0);
		push_tick(0, 0, 1, 0, CMD_NONE, 0, 0);
		push_tick(0, 0, 1, 0, CMD_MOVE_BY, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_tick(0, 0, 1, 0, CMD_MOVE_TO, 32'h8000_0000, 32'h8000_0000);
		add_goal(MODE_SHOOT, 32'h8000_0000, PITCH_LOW_LIMIT_RST, 1'b1);
		push_tick(0, 0, 1, 0, 2'd3, DEG, DEG);
		push_tick(0, 0, 1, 0, CMD_MOVE_BY, -DEG, -2 * DEG);
		push_tick(0, 0, 1, 0, CMD_MOVE_TO, 0, 0);
		add_goal(MODE_SHOOT, 0, 0, 1'b0);
		// shoot ignores remote
		push_tick(0, 0, 1, 1, CMD_MOVE_BY, DEG, DEG);
		push_tick(0, 0, 0, 0, CMD_NONE, 0, 0);
		// remote wins over host from cruise
		push_tick(0, 0, 1, 1, CMD_NONE, 0, 0);
		push_tick(0, 0, 0, 1, CMD_MOVE_TO, 7 * DEG, 7 * DEG);
		// remote release and host online both clear the chassis target
		push_tick(0, 0, 0, 0, CMD_NONE, 0, 0);
		push_tick(0, 0, 0, 1, CMD_NONE, 0, 0);
		push_tick(0, 0, 1, 1, CMD_NONE, 0, 0);
		push_tick(0, 0, 0, 0, CMD_NONE, 0, 0);
		// cruise until the scan step on the eleventh cruise tick
		for (int k = 0; k < 7; k++)
			push_tick(0, 0, 0, 0, CMD_MOVE_TO, DEG, DEG);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[k]) begin
			case (rows[k].kind)
				ROW_TICK: send_tick(rows[k].t, rows[k].has_exp, rows[k].e);
				ROW_REG: begin
					wait_drained();
					apply_reg(rows[k].idx, rows[k].val);
					wr_en <= 1'b0;
				end
				default: begin
					set_idling(0);
					for (int n = 0; n < rows[k].val; n++)
						send_tick(random_tick(), 1'b0, '0);
					set_idling(3);
				end
			endcase
		end

		// random part over several register settings
		for (int s = 0; s < 6; s++) begin
			wait_drained();
			case (s)
				0: write_set(0, -20 * DEG, 30 * DEG, 0, DEG, DEG / 2);
				1: write_set(100, -10 * DEG, 10 * DEG, -5 * DEG, -3 * DEG, 3 * DEG);
				2: write_set(32'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
						32'h7FFF_FFFF, 32'h7FFF_FFFF);
				3: write_set(0, 5 * DEG, -5 * DEG, 32'h7FFF_FFFF, 32'h8000_0000, 0);
				4: write_set(1, 0, 12 * DEG, 0, 7, DEG);
				default: write_set($urandom_range(65535), -$urandom_range(30 * DEG),
						$urandom_range(30 * DEG), $urandom, $urandom,
						$urandom_range(8 * DEG));
			endcase
			for (int i = 0; i < 220; i++) begin
				set_idling((i / 55) % 4);
				send_tick(random_tick(), 1'b0, '0);
			end
		end

		tick_ch.valid <= 1'b0;
		for (int w = 0; w < 4000 && pending_goals.size() != 0; w++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (bad == 0 && pending_goals.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[gimbal_mode_and_scan_target_unit.f]
+incdir+rtl/core
rtl/core/gmst_pkg.sv
rtl/core/gmst_tick_if.sv
rtl/core/gmst_goal_if.sv
rtl/core/gimbal_mode_and_scan_target_unit.sv
tb/tb.sv
